// File: src/jtl_pkg.sv
`default_nettype none
package jtl_pkg;

	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_STRING  = 3'd1;
	localparam logic [2:0] MODE_NUMBER  = 3'd2;
	localparam logic [2:0] MODE_LITERAL = 3'd3;
	localparam logic [2:0] MODE_ERROR   = 3'd4;

	localparam logic [1:0] EV_VALUE = 2'd0;
	localparam logic [1:0] EV_TOKEN = 2'd1;
	localparam logic [1:0] EV_ERROR = 2'd2;

	localparam logic [3:0] TOK_STRING   = 4'd0;
	localparam logic [3:0] TOK_NUMBER   = 4'd1;
	localparam logic [3:0] TOK_TRUE     = 4'd2;
	localparam logic [3:0] TOK_COLON    = 4'd5;
	localparam logic [3:0] TOK_COMMA    = 4'd6;
	localparam logic [3:0] TOK_OBJ_OPEN = 4'd7;
	localparam logic [3:0] TOK_OBJ_CLOSE = 4'd8;
	localparam logic [3:0] TOK_ARR_OPEN = 4'd9;
	localparam logic [3:0] TOK_ARR_CLOSE = 4'd10;

	localparam logic [2:0] ERR_BAD_CHAR    = 3'd0;
	localparam logic [2:0] ERR_ESCAPE      = 3'd1;
	localparam logic [2:0] ERR_UNTERM_STR  = 3'd2;
	localparam logic [2:0] ERR_BAD_NUMBER  = 3'd3;
	localparam logic [2:0] ERR_BAD_LITERAL = 3'd4;

	localparam logic [1:0] LIT_TRUE  = 2'd0;
	localparam logic [1:0] LIT_FALSE = 2'd1;
	localparam logic [1:0] LIT_NULL  = 2'd2;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NL      = 8'h0a;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_BSLASH  = 8'h5c;
	localparam logic [7:0] CH_POINT   = 8'h2e;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_COLON   = 8'h3a;
	localparam logic [7:0] CH_COMMA   = 8'h2c;
	localparam logic [7:0] CH_LBRACE  = 8'h7b;
	localparam logic [7:0] CH_RBRACE  = 8'h7d;
	localparam logic [7:0] CH_LBRACK  = 8'h5b;
	localparam logic [7:0] CH_RBRACK  = 8'h5d;
	localparam logic [7:0] CH_T       = 8'h74;
	localparam logic [7:0] CH_F       = 8'h66;
	localparam logic [7:0] CH_N       = 8'h6e;

	typedef struct packed {
		logic [2:0] mode;
		logic       seen_point;
		logic       digit_since_point;
		logic [1:0] literal_target;
		logic [2:0] literal_position;
		logic       literal_mismatch;
	} lex_state_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [3:0] token_kind;
		logic [7:0] value_byte;
		logic [2:0] error_code;
		logic       last_of_run;
	} lex_res_t;

	localparam lex_state_t STATE_RESET = '{
		mode: MODE_IDLE, seen_point: 1'b0, digit_since_point: 1'b0,
		literal_target: LIT_TRUE, literal_position: 3'd0, literal_mismatch: 1'b0
	};

	function automatic logic [1:0] lit_clamp(input logic [1:0] target);
		return (target == 2'd3) ? LIT_TRUE : target;
	endfunction

	function automatic logic [2:0] lit_len(input logic [1:0] target);
		return (target == LIT_FALSE) ? 3'd5 : 3'd4;
	endfunction

	// character of "true", "false", "null" at a position
	function automatic logic [7:0] lit_char(input logic [1:0] target, input logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		case (target)
			LIT_FALSE: begin
				case (pos)
					3'd0: ch = "f";
					3'd1: ch = "a";
					3'd2: ch = "l";
					3'd3: ch = "s";
					3'd4: ch = "e";
					default: ch = 8'h00;
				endcase
			end
			LIT_NULL: begin
				case (pos)
					3'd0: ch = "n";
					3'd1: ch = "u";
					3'd2: ch = "l";
					3'd3: ch = "l";
					default: ch = 8'h00;
				endcase
			end
			default: begin
				case (pos)
					3'd0: ch = "t";
					3'd1: ch = "r";
					3'd2: ch = "u";
					3'd3: ch = "e";
					default: ch = 8'h00;
				endcase
			end
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

// File: src/jtl_if.sv
`default_nettype none
interface jtl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface jtl_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic [3:0] token_kind;
	logic [7:0] value_byte;
	logic [2:0] error_code;
	logic       last_of_run;

	modport source (output valid, output event_kind, output token_kind, output value_byte,
		output error_code, output last_of_run, input ready);
	modport sink   (input valid, input event_kind, input token_kind, input value_byte,
		input error_code, input last_of_run, output ready);
endinterface
`default_nettype wire

// File: src/jtl_lex.sv
`default_nettype none
module jtl_lex (
	input  wire jtl_pkg::lex_state_t            st,
	input  wire logic [7:0]                     c,
	input  wire logic                           last,
	output jtl_pkg::lex_state_t                 nx,
	output logic [1:0]                          n,
	output jtl_pkg::lex_res_t [1:0]             res
);

	function automatic void put(inout jtl_pkg::lex_res_t [1:0] rs, inout logic [1:0] cnt,
		input logic [1:0] ev, input logic [3:0] tok, input logic [7:0] val,
		input logic [2:0] err);
		if (cnt < 2'd2) begin
			rs[cnt[0]] = '{event_kind: ev, token_kind: tok, value_byte: val,
				error_code: err, last_of_run: 1'b0};
			cnt = cnt + 2'd1;
		end
	endfunction

	logic is_digit;
	logic is_alpha;
	assign is_digit = (c >= "0") && (c <= "9");
	assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));

	always_comb begin
		logic       closed;
		logic       go_idle;
		logic [1:0] t;
		logic [1:0] cnt;
		jtl_pkg::lex_res_t [1:0] rs;
		closed  = 1'b0;
		go_idle = 1'b0;
		t       = 2'd0;
		cnt     = 2'd0;
		rs      = '0;
		nx      = st;

		case (st.mode)
			jtl_pkg::MODE_ERROR: begin
			end
			jtl_pkg::MODE_STRING: begin
				if (c == jtl_pkg::CH_QUOTE) begin
					put(rs, cnt, jtl_pkg::EV_TOKEN, jtl_pkg::TOK_STRING, 8'h00, 3'd0);
					nx.mode = jtl_pkg::MODE_IDLE;
				end else if (c == jtl_pkg::CH_BSLASH) begin
					put(rs, cnt, jtl_pkg::EV_ERROR, 4'd0, 8'h00, jtl_pkg::ERR_ESCAPE);
					nx.mode = jtl_pkg::MODE_ERROR;
				end else if (c == jtl_pkg::CH_NL) begin
					put(rs, cnt, jtl_pkg::EV_ERROR, 4'd0, 8'h00, jtl_pkg::ERR_UNTERM_STR);
					nx.mode = jtl_pkg::MODE_ERROR;
				end else begin
					put(rs, cnt, jtl_pkg::EV_VALUE, 4'd0, c, 3'd0);
				end
			end
			jtl_pkg::MODE_NUMBER: begin
				if (is_digit) begin
					put(rs, cnt, jtl_pkg::EV_VALUE, 4'd0, c, 3'd0);
					nx.digit_since_point = 1'b1;
				end else if (c == jtl_pkg::CH_POINT) begin
					if (st.seen_point) begin
						put(rs, cnt, jtl_pkg::EV_ERROR, 4'd0, 8'h00, jtl_pkg::ERR_BAD_NUMBER);
						nx.mode = jtl_pkg::MODE_ERROR;
					end else begin
						put(rs, cnt, jtl_pkg::EV_VALUE, 4'd0, c, 3'd0);
						nx.seen_point        = 1'b1;
						nx.digit_since_point = 1'b0;
					end
				end else if (st.digit_since_point) begin
					put(rs, cnt, jtl_pkg::EV_TOKEN, jtl_pkg::TOK_NUMBER, 8'h00, 3'd0);
					nx.mode = jtl_pkg::MODE_IDLE;
					closed  = 1'b1;
				end else begin
					put(rs, cnt, jtl_pkg::EV_ERROR, 4'd0, 8'h00, jtl_pkg::ERR_BAD_NUMBER);
					nx.mode = jtl_pkg::MODE_ERROR;
				end
			end
			jtl_pkg::MODE_LITERAL: begin
				t = jtl_pkg::lit_clamp(st.literal_target);
				if (is_alpha) begin
					if (st.literal_position >= jtl_pkg::lit_len(t) ||
						jtl_pkg::lit_char(t, st.literal_position) != c)
						nx.literal_mismatch = 1'b1;
					if (st.literal_position != 3'd7)
						nx.literal_position = st.literal_position + 3'd1;
				end else if (!st.literal_mismatch && st.literal_position == jtl_pkg::lit_len(t)) begin
					put(rs, cnt, jtl_pkg::EV_TOKEN, jtl_pkg::TOK_TRUE + {2'b00, t}, 8'h00, 3'd0);
					nx.mode = jtl_pkg::MODE_IDLE;
					closed  = 1'b1;
				end else begin
					put(rs, cnt, jtl_pkg::EV_ERROR, 4'd0, 8'h00, jtl_pkg::ERR_BAD_LITERAL);
					nx.mode = jtl_pkg::MODE_ERROR;
				end
			end
			default: begin
				nx.mode = jtl_pkg::MODE_IDLE;
				go_idle = 1'b1;
			end
		endcase

		// a byte that ended a number or literal is lexed again as a fresh byte
		if (go_idle || closed) begin
			case (c)
				jtl_pkg::CH_SPACE, jtl_pkg::CH_TAB, jtl_pkg::CH_NL: begin
				end
				jtl_pkg::CH_QUOTE: nx.mode = jtl_pkg::MODE_STRING;
				jtl_pkg::CH_T, jtl_pkg::CH_F, jtl_pkg::CH_N: begin
					nx.literal_target   = (c == jtl_pkg::CH_T) ? jtl_pkg::LIT_TRUE :
						(c == jtl_pkg::CH_F) ? jtl_pkg::LIT_FALSE : jtl_pkg::LIT_NULL;
					nx.literal_position = 3'd1;
					nx.literal_mismatch = 1'b0;
					nx.mode             = jtl_pkg::MODE_LITERAL;
				end
				jtl_pkg::CH_COLON:
					put(rs, cnt, jtl_pkg::EV_TOKEN, jtl_pkg::TOK_COLON, 8'h00, 3'd0);
				jtl_pkg::CH_COMMA:
					put(rs, cnt, jtl_pkg::EV_TOKEN, jtl_pkg::TOK_COMMA, 8'h00, 3'd0);
				jtl_pkg::CH_LBRACE:
					put(rs, cnt, jtl_pkg::EV_TOKEN, jtl_pkg::TOK_OBJ_OPEN, 8'h00, 3'd0);
				jtl_pkg::CH_RBRACE:
					put(rs, cnt, jtl_pkg::EV_TOKEN, jtl_pkg::TOK_OBJ_CLOSE, 8'h00, 3'd0);
				jtl_pkg::CH_LBRACK:
					put(rs, cnt, jtl_pkg::EV_TOKEN, jtl_pkg::TOK_ARR_OPEN, 8'h00, 3'd0);
				jtl_pkg::CH_RBRACK:
					put(rs, cnt, jtl_pkg::EV_TOKEN, jtl_pkg::TOK_ARR_CLOSE, 8'h00, 3'd0);
				default: begin
					if (is_digit || c == jtl_pkg::CH_MINUS) begin
						if (closed && last) begin
							put(rs, cnt, jtl_pkg::EV_ERROR, 4'd0, 8'h00,
								jtl_pkg::ERR_BAD_NUMBER);
							nx.mode = jtl_pkg::MODE_ERROR;
						end else begin
							put(rs, cnt, jtl_pkg::EV_VALUE, 4'd0, c, 3'd0);
							nx.seen_point        = 1'b0;
							nx.digit_since_point = is_digit;
							nx.mode              = jtl_pkg::MODE_NUMBER;
						end
					end else begin
						put(rs, cnt, jtl_pkg::EV_ERROR, 4'd0, 8'h00, jtl_pkg::ERR_BAD_CHAR);
						nx.mode = jtl_pkg::MODE_ERROR;
					end
				end
			endcase
		end

		// final byte closes whatever is still open, then back to reset
		if (last) begin
			t = jtl_pkg::lit_clamp(nx.literal_target);
			case (nx.mode)
				jtl_pkg::MODE_STRING:
					put(rs, cnt, jtl_pkg::EV_ERROR, 4'd0, 8'h00, jtl_pkg::ERR_UNTERM_STR);
				jtl_pkg::MODE_NUMBER: begin
					if (nx.digit_since_point)
						put(rs, cnt, jtl_pkg::EV_TOKEN, jtl_pkg::TOK_NUMBER, 8'h00, 3'd0);
					else
						put(rs, cnt, jtl_pkg::EV_ERROR, 4'd0, 8'h00, jtl_pkg::ERR_BAD_NUMBER);
				end
				jtl_pkg::MODE_LITERAL: begin
					if (!nx.literal_mismatch && nx.literal_position == jtl_pkg::lit_len(t))
						put(rs, cnt, jtl_pkg::EV_TOKEN, jtl_pkg::TOK_TRUE + {2'b00, t},
							8'h00, 3'd0);
					else
						put(rs, cnt, jtl_pkg::EV_ERROR, 4'd0, 8'h00, jtl_pkg::ERR_BAD_LITERAL);
				end
				default: begin
				end
			endcase
			nx = jtl_pkg::STATE_RESET;
		end

		if (cnt == 2'd1)
			rs[0].last_of_run = 1'b1;
		else if (cnt == 2'd2)
			rs[1].last_of_run = 1'b1;
		n   = cnt;
		res = rs;
	end

endmodule
`default_nettype wire

// File: src/jtl_outbuf.sv
`default_nettype none
module jtl_outbuf (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       load,
	input  wire logic [1:0]                 load_n,
	input  wire jtl_pkg::lex_res_t [1:0]    load_res,
	output logic                            free,
	jtl_out_if.source                       dst
);

	logic [1:0]        cnt_q;
	jtl_pkg::lex_res_t r0_q;
	jtl_pkg::lex_res_t r1_q;
	logic              pop;

	assign pop  = dst.valid && dst.ready;
	// room for a new pair once the last held item leaves this cycle
	assign free = (cnt_q == 2'd0) || (cnt_q == 2'd1 && dst.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= load_n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			r0_q <= load_res[0];
			r1_q <= load_res[1];
		end else if (pop) begin
			r0_q <= r1_q;
		end
	end

	assign dst.valid       = (cnt_q != 2'd0);
	assign dst.event_kind  = r0_q.event_kind;
	assign dst.token_kind  = r0_q.token_kind;
	assign dst.value_byte  = r0_q.value_byte;
	assign dst.error_code  = r0_q.error_code;
	assign dst.last_of_run = r0_q.last_of_run;

endmodule
`default_nettype wire

// File: src/json_token_lexer.sv
`default_nettype none
// Streaming JSON lexer. Each byte of the text enters on the text channel, the
// final one flagged by end_of_text; the events channel gives value bytes of
// strings and numbers, token completions and errors, at most two items per
// byte, last_of_run marking the last one. A byte is registered, lexed against
// the lexer state combinationally and its results land in a two-item output
// register, so a byte is taken every clock while each gives at most one item
// and the events side is ready; a byte giving two items holds back the next
// byte giving items. Bytes giving none pass even with the output stalled.
// After an error nothing is reported until the final byte, which resets all.
module json_token_lexer (
	input  wire logic  clk,
	input  wire logic  arst_n,
	jtl_in_if.sink     text,
	jtl_out_if.source  events
);

	logic                    s1_valid;
	logic [7:0]              byte_s1;
	logic                    last_s1;
	jtl_pkg::lex_state_t     state_q;
	jtl_pkg::lex_state_t     state_nx;
	logic [1:0]              res_n;
	jtl_pkg::lex_res_t [1:0] res;
	logic                    ob_free;
	logic                    take;

	assign take       = s1_valid && (res_n == 2'd0 || ob_free);
	assign text.ready = !s1_valid || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			state_q  <= jtl_pkg::STATE_RESET;
		end else begin
			if (text.ready)
				s1_valid <= text.valid;
			if (take)
				state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.in_byte;
			last_s1 <= text.end_of_text;
		end
	end

	jtl_lex u_lex (
		.st  (state_q),
		.c   (byte_s1),
		.last(last_s1),
		.nx  (state_nx),
		.n   (res_n),
		.res (res)
	);

	jtl_outbuf u_outbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (take && res_n != 2'd0),
		.load_n  (res_n),
		.load_res(res),
		.free    (ob_free),
		.dst     (events)
	);

endmodule
`default_nettype wire

// File: src/jtl_checker.sv
`default_nettype none
module jtl_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       ev_valid,
	input wire logic       ev_ready,
	input wire logic [1:0] event_kind,
	input wire logic [3:0] token_kind,
	input wire logic [7:0] value_byte,
	input wire logic [2:0] error_code,
	input wire logic       last_of_run
);

	a_kind_known: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid |-> (event_kind == jtl_pkg::EV_VALUE || event_kind == jtl_pkg::EV_TOKEN ||
			event_kind == jtl_pkg::EV_ERROR))
		else $error("unknown event kind");

	a_token_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_valid && event_kind != jtl_pkg::EV_TOKEN) |-> token_kind == 4'd0)
		else $error("token kind set on non-token item");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_valid && event_kind != jtl_pkg::EV_VALUE) |-> value_byte == 8'h00)
		else $error("value byte set on non-value item");

	// an error always closes the run of its byte
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_valid && event_kind == jtl_pkg::EV_ERROR) |-> last_of_run)
		else $error("error item not last of run");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_valid && !ev_ready) |=> ev_valid && $stable(event_kind) && $stable(token_kind)
			&& $stable(value_byte) && $stable(error_code) && $stable(last_of_run))
		else $error("stalled item changed");

endmodule

bind json_token_lexer jtl_checker u_jtl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.ev_valid   (events.valid),
	.ev_ready   (events.ready),
	.event_kind (events.event_kind),
	.token_kind (events.token_kind),
	.value_byte (events.value_byte),
	.error_code (events.error_code),
	.last_of_run(events.last_of_run)
);
`default_nettype wire

// File: verif/json_token_lexer_tb.sv
`default_nettype none
module json_token_lexer_tb;
	import jtl_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} text_item_t;

	logic clk = 1'b0;
	logic arst_n;

	jtl_in_if  text_ch ();
	jtl_out_if ev_ch ();

	json_token_lexer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.events (ev_ch)
	);

	always #6 clk = ~clk;

	text_item_t text_bytes[$];
	lex_res_t   expected_events[$];
	lex_res_t   step_out[$];
	lex_state_t lx;

	int  mismatches = 0;
	int  accepted = 0;
	int  received = 0;
	int  total_bytes;
	bit  drain_pending = 1'b0;
	bit  drain_done = 1'b0;
	bit  hold_done = 1'b0;
	int  hold_left = 0;

	task automatic flag_mismatch(input string what);
		$display("lexer check @%0t: %s", $realtime, what);
		mismatches++;
	endtask

	// ---------------- lexer prediction ----------------

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic int word_length(input logic [1:0] t);
		return (t == LIT_FALSE) ? 5 : 4;
	endfunction

	function automatic logic [7:0] word_letter(input logic [1:0] t, input logic [2:0] p);
		string w;
		w = (t == LIT_FALSE) ? "false" : (t == LIT_NULL) ? "null" : "true";
		return (p < w.len()) ? w[p] : 8'h00;
	endfunction

	function automatic logic [1:0] word_target();
		return (lx.literal_target > LIT_NULL) ? LIT_TRUE : lx.literal_target;
	endfunction

	// a byte never gives more than two events
	function automatic void emit(input logic [1:0] ev, input logic [3:0] tok,
		input logic [7:0] val, input logic [2:0] err);
		lex_res_t r;
		if (step_out.size() >= 2)
			return;
		r.event_kind = ev;
		r.token_kind = tok;
		r.value_byte = val;
		r.error_code = err;
		r.last_of_run = 1'b0;
		step_out.insert(step_out.size(), r);
	endfunction

	function automatic bit close_number();
		if (lx.digit_since_point) begin
			emit(EV_TOKEN, TOK_NUMBER, '0, '0);
			lx.mode = MODE_IDLE;
			return 1'b1;
		end
		emit(EV_ERROR, '0, '0, ERR_BAD_NUMBER);
		lx.mode = MODE_ERROR;
		return 1'b0;
	endfunction

	function automatic bit close_literal();
		logic [1:0] t;
		t = word_target();
		if (!lx.literal_mismatch && lx.literal_position == word_length(t)) begin
			emit(EV_TOKEN, TOK_TRUE + 4'(t), '0, '0);
			lx.mode = MODE_IDLE;
			return 1'b1;
		end
		emit(EV_ERROR, '0, '0, ERR_BAD_LITERAL);
		lx.mode = MODE_ERROR;
		return 1'b0;
	endfunction

	function automatic void literal_step(input logic [7:0] c);
		logic [1:0] t;
		t = word_target();
		if (lx.literal_position >= word_length(t) || word_letter(t, lx.literal_position) != c)
			lx.literal_mismatch = 1'b1;
		if (lx.literal_position < 3'd7)
			lx.literal_position++;
	endfunction

	// crowded: this final byte just closed a number/literal and would open a number
	function automatic void idle_byte(input logic [7:0] c, input bit crowded);
		case (c)
			CH_SPACE, CH_TAB, CH_NL: begin
			end
			CH_QUOTE: lx.mode = MODE_STRING;
			CH_T, CH_F, CH_N: begin
				lx.literal_target = (c == CH_T) ? LIT_TRUE : (c == CH_F) ? LIT_FALSE : LIT_NULL;
				lx.literal_position = '0;
				lx.literal_mismatch = 1'b0;
				literal_step(c);
				lx.mode = MODE_LITERAL;
			end
			CH_COLON:  emit(EV_TOKEN, TOK_COLON, '0, '0);
			CH_COMMA:  emit(EV_TOKEN, TOK_COMMA, '0, '0);
			CH_LBRACE: emit(EV_TOKEN, TOK_OBJ_OPEN, '0, '0);
			CH_RBRACE: emit(EV_TOKEN, TOK_OBJ_CLOSE, '0, '0);
			CH_LBRACK: emit(EV_TOKEN, TOK_ARR_OPEN, '0, '0);
			CH_RBRACK: emit(EV_TOKEN, TOK_ARR_CLOSE, '0, '0);
			default: begin
				if (is_digit(c) || c == CH_MINUS) begin
					if (crowded) begin
						emit(EV_ERROR, '0, '0, ERR_BAD_NUMBER);
						lx.mode = MODE_ERROR;
					end else begin
						emit(EV_VALUE, '0, c, '0);
						lx.seen_point = 1'b0;
						lx.digit_since_point = is_digit(c);
						lx.mode = MODE_NUMBER;
					end
				end else begin
					emit(EV_ERROR, '0, '0, ERR_BAD_CHAR);
					lx.mode = MODE_ERROR;
				end
			end
		endcase
	endfunction

	task automatic lex_byte(input logic [7:0] c, input logic fin);
		bit closed;
		bit go_idle;
		closed = 1'b0;
		go_idle = 1'b0;
		step_out.delete();
		case (lx.mode)
			MODE_ERROR: begin
			end
			MODE_STRING: begin
				if (c == CH_QUOTE) begin
					emit(EV_TOKEN, TOK_STRING, '0, '0);
					lx.mode = MODE_IDLE;
				end else if (c == CH_BSLASH) begin
					emit(EV_ERROR, '0, '0, ERR_ESCAPE);
					lx.mode = MODE_ERROR;
				end else if (c == CH_NL) begin
					emit(EV_ERROR, '0, '0, ERR_UNTERM_STR);
					lx.mode = MODE_ERROR;
				end else begin
					emit(EV_VALUE, '0, c, '0);
				end
			end
			MODE_NUMBER: begin
				if (is_digit(c)) begin
					emit(EV_VALUE, '0, c, '0);
					lx.digit_since_point = 1'b1;
				end else if (c == CH_POINT) begin
					if (lx.seen_point) begin
						emit(EV_ERROR, '0, '0, ERR_BAD_NUMBER);
						lx.mode = MODE_ERROR;
					end else begin
						emit(EV_VALUE, '0, c, '0);
						lx.seen_point = 1'b1;
						lx.digit_since_point = 1'b0;
					end
				end else begin
					closed = close_number();
					go_idle = closed;
				end
			end
			MODE_LITERAL: begin
				if (is_alpha(c)) begin
					literal_step(c);
				end else begin
					closed = close_literal();
					go_idle = closed;
				end
			end
			default: begin
				lx.mode = MODE_IDLE;
				go_idle = 1'b1;
			end
		endcase
		if (go_idle)
			idle_byte(c, closed && fin);
		if (fin) begin
			if (lx.mode == MODE_STRING)
				emit(EV_ERROR, '0, '0, ERR_UNTERM_STR);
			else if (lx.mode == MODE_NUMBER)
				void'(close_number());
			else if (lx.mode == MODE_LITERAL)
				void'(close_literal());
			lx = STATE_RESET;
		end
		if (step_out.size() > 0)
			step_out[step_out.size() - 1].last_of_run = 1'b1;
		foreach (step_out[i])
			expected_events.insert(expected_events.size(), step_out[i]);
	endtask

	// ---------------- text generation ----------------

	task automatic add_byte(input logic [7:0] c);
		text_item_t t;
		t.ch = c;
		t.fin = 1'b0;
		text_bytes.insert(text_bytes.size(), t);
	endtask

	task automatic add_chars(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic close_text();
		text_bytes[text_bytes.size() - 1].fin = 1'b1;
	endtask

	task automatic add_digits(input int n);
		repeat (n) add_byte(8'("0" + $urandom_range(0, 9)));
	endtask

	task automatic add_token();
		logic [7:0] c;
		string w;
		int n;
		int m;
		case ($urandom_range(0, 9))
			0, 1: begin
				add_byte(CH_QUOTE);
				n = $urandom_range(0, 6);
				repeat (n) begin
					c = 8'($urandom_range(0, 255));
					if (c == CH_QUOTE || c == CH_BSLASH || c == CH_NL)
						c = c ^ 8'h40;
					add_byte(c);
				end
				if ($urandom_range(0, 24) == 0)
					add_byte($urandom_range(0, 1) ? CH_BSLASH : CH_NL);
				add_byte(CH_QUOTE);
			end
			2, 3: begin
				if ($urandom_range(0, 2) == 0)
					add_byte(CH_MINUS);
				add_digits($urandom_range(1, 4));
				if ($urandom_range(0, 2) == 0) begin
					add_byte(CH_POINT);
					add_digits($urandom_range(0, 3));
					if ($urandom_range(0, 15) == 0)
						add_byte(CH_POINT);
				end
			end
			4, 5: begin
				case ($urandom_range(0, 2))
					0: w = "true";
					1: w = "false";
					default: w = "null";
				endcase
				n = w.len();
				m = $urandom_range(0, 11);
				if (m == 0)
					n--;
				for (int i = 0; i < n; i++) begin
					c = w[i];
					if (m == 1 && i == n - 1)
						c = c ^ 8'h20;
					add_byte(c);
				end
				if (m == 2)
					add_byte("s");
				// run long enough to saturate the position count
				if (m == 3)
					add_chars("ness");
			end
			default: begin
				case ($urandom_range(0, 5))
					0: add_byte(CH_COLON);
					1: add_byte(CH_COMMA);
					2: add_byte(CH_LBRACE);
					3: add_byte(CH_RBRACE);
					4: add_byte(CH_LBRACK);
					default: add_byte(CH_RBRACK);
				endcase
			end
		endcase
	endtask

	task automatic add_random_text();
		int n;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 6);
			repeat (n) add_byte(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(1, 10);
			repeat (n) begin
				add_token();
				if ($urandom_range(0, 1) == 0) begin
					case ($urandom_range(0, 2))
						0: add_byte(CH_SPACE);
						1: add_byte(CH_TAB);
						default: add_byte(CH_NL);
					endcase
				end
				if ($urandom_range(0, 32) == 0)
					add_byte(8'($urandom_range(0, 255)));
			end
		end
		close_text();
	endtask

	// ---------------- text side ----------------

	always @(posedge clk) begin : drive_text
		text_item_t nxt;
		if (arst_n) begin
			if (text_ch.valid && text_ch.ready) begin
				lex_byte(text_ch.in_byte, text_ch.end_of_text);
				accepted++;
			end
			if (!text_ch.valid || text_ch.ready) begin
				if (accepted == 500 && !drain_done) begin
					drain_pending = 1'b1;
					drain_done = 1'b1;
				end
				if (drain_pending && expected_events.size() == 0)
					drain_pending = 1'b0;
				if (text_bytes.size() > 0 && !drain_pending &&
					((accepted >= 300 && accepted < 450) || $urandom_range(0, 99) >= 26)) begin
					nxt = text_bytes.pop_front();
					text_ch.valid <= 1'b1;
					text_ch.in_byte <= nxt.ch;
					text_ch.end_of_text <= nxt.fin;
				end else begin
					text_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- event side ----------------

	always @(posedge clk) begin : collect_events
		lex_res_t want;
		if (arst_n) begin
			if (ev_ch.valid && ev_ch.ready) begin
				received++;
				if (expected_events.size() == 0) begin
					flag_mismatch($sformatf("event kind %0d with none expected",
						ev_ch.event_kind));
				end else begin
					want = expected_events.pop_front();
					if (ev_ch.event_kind !== want.event_kind)
						flag_mismatch($sformatf("event_kind %0d, expected %0d",
							ev_ch.event_kind, want.event_kind));
					if (ev_ch.token_kind !== want.token_kind)
						flag_mismatch($sformatf("token_kind %0d, expected %0d",
							ev_ch.token_kind, want.token_kind));
					if (ev_ch.value_byte !== want.value_byte)
						flag_mismatch($sformatf("value_byte %h, expected %h",
							ev_ch.value_byte, want.value_byte));
					if (ev_ch.error_code !== want.error_code)
						flag_mismatch($sformatf("error_code %0d, expected %0d",
							ev_ch.error_code, want.error_code));
					if (ev_ch.last_of_run !== want.last_of_run)
						flag_mismatch($sformatf("last_of_run %0d, expected %0d",
							ev_ch.last_of_run, want.last_of_run));
				end
			end
			// long hold-off: input side keeps offering so the lexer backs up
			if (received == 80 && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 60;
			end
			if (hold_left > 0) begin
				hold_left--;
				ev_ch.ready <= 1'b0;
			end else begin
				ev_ch.ready <= (received >= 300 && received < 450) ||
					$urandom_range(0, 99) >= 26;
			end
		end
	end

	// ---------------- sequence ----------------

	initial begin
		arst_n = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.in_byte = '0;
		text_ch.end_of_text = 1'b0;
		ev_ch.ready = 1'b0;
		lx = STATE_RESET;

		// strings, numbers, every punctuator, adjacent tokens, crowded final byte
		add_chars("[\"");
		add_byte(8'hff);
		add_chars("\",1.5]{}:null7");
		close_text();
		// escape, then error hold through the final byte
		add_chars("\"\\xy");
		close_text();
		add_byte(8'h00);
		close_text();
		// string left open at end
		add_byte(CH_QUOTE);
		add_byte(8'h80);
		close_text();
		// number left pending at end without a digit
		add_chars("false -");
		close_text();

		while (text_bytes.size() < 700)
			add_random_text();
		total_bytes = text_bytes.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted < total_bytes)
			@(posedge clk);
		while (expected_events.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		if (mismatches == 0)
			$display("json_token_lexer_tb: clean");
		else
			$display("json_token_lexer_tb: errors");
		$finish;
	end

	initial begin
		#2400000;
		$display("json_token_lexer_tb: errors");
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
src/jtl_pkg.sv
src/jtl_if.sv
src/jtl_lex.sv
src/jtl_outbuf.sv
src/json_token_lexer.sv
src/jtl_checker.sv
verif/json_token_lexer_tb.sv
